/* hw/rtl/ipa_pkg.sv */
package ipa_pkg;

   localparam int MAX_IDS_DEF = 64;
   localparam int ID_W        = 6;
   localparam int CAP_W       = 7;
   localparam int ENTRY_W     = 7;
   localparam int FC_W        = 7;
   localparam int CAP_RESET   = 64;
   localparam int CSR_IDX_W   = 1;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_POP,
      ST_SCAN,
      ST_MOVE
   } state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY,
      CSR_LOWEST_FIRST
   } csr_idx_type;

   typedef enum logic {
      CMD_TAKE,
      CMD_RETURN
   } cmd_type;

   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctl_type;

endpackage

/* hw/rtl/ipa_ram.sv */
module ipa_ram #(
   parameter int WIDTH = ipa_pkg::ENTRY_W,
   parameter int DEPTH = ipa_pkg::MAX_IDS_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/ipa_min_scan.sv */
module ipa_min_scan #(
   parameter int POS_W = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ipa_pkg::scan_ctl_type       ctl,
   input  logic [ipa_pkg::ENTRY_W-1:0] val,
   input  logic [POS_W-1:0]            pos,
   output logic [ipa_pkg::ENTRY_W-1:0] best_val,
   output logic [POS_W-1:0]            best_pos
);

   logic                        have_ff, have_in;
   logic [ipa_pkg::ENTRY_W-1:0] best_val_ff, best_val_in;
   logic [POS_W-1:0]            best_pos_ff, best_pos_in;

   // strict less-than keeps the first occurrence of the minimum
   always_comb begin
      have_in     = have_ff;
      best_val_in = best_val_ff;
      best_pos_in = best_pos_ff;
      if (ctl.clear) begin
         have_in = 1'b0;
      end else if (ctl.sample && (!have_ff || val < best_val_ff)) begin
         have_in     = 1'b1;
         best_val_in = val;
         best_pos_in = pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      best_val_ff <= best_val_in;
      best_pos_ff <= best_pos_in;
   end

   assign best_val = best_val_ff;
   assign best_pos = best_pos_ff;

   a_sample_sets_have: assert property (@(posedge clock) disable iff (reset)
      (ctl.sample && !ctl.clear) |=> have_ff)
      else $error("min scan lost its first sample");

   a_min_never_grows: assert property (@(posedge clock) disable iff (reset)
      (have_ff && !ctl.clear) |=> (best_val_ff <= $past(best_val_ff)))
      else $error("min scan value increased");

   a_clear_drops: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> !have_ff)
      else $error("min scan not cleared");

endmodule

/* hw/rtl/id_pool_allocator.sv */
// Channel   Direction  Ports                                    Handshake
// request   in         req_cmd, req_return_id                   start && !busy
// response  out        rsp_granted_id, rsp_granted,             rsp_valid, one cycle
//                      rsp_pool_empty, rsp_free_count, rsp_overflow
// csr       in         csr_index, csr_wdata                     csr_we
//
// Return, or take on an empty list: response in the cycle after the beat.
// Last-freed take: one RAM read, then the POP state registers the response.
// Lowest-first take: a SCAN pass reads every entry to find the minimum, then a
// MOVE pass shifts the entries after it down by one; both go through the single
// RAM read port shared by the min scan and the compaction pass.
// Reset and each capacity write run a fill pass of min(capacity, MAX_IDS)
// entries with busy high. Responses cannot be stalled.
module id_pool_allocator #(
   parameter int MAX_IDS = ipa_pkg::MAX_IDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic [ipa_pkg::ID_W-1:0]      req_return_id,
   output logic                          rsp_valid,
   output logic [ipa_pkg::ID_W-1:0]      rsp_granted_id,
   output logic                          rsp_granted,
   output logic                          rsp_pool_empty,
   output logic [ipa_pkg::FC_W-1:0]      rsp_free_count,
   output logic                          rsp_overflow,
   input  logic                          csr_we,
   input  logic [ipa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ipa_pkg::CAP_W-1:0]     csr_wdata
);

   localparam int AW      = $clog2(MAX_IDS);
   localparam int CNT_W   = $clog2(MAX_IDS + 1);
   localparam int RESET_N = (ipa_pkg::CAP_RESET > MAX_IDS) ? MAX_IDS : ipa_pkg::CAP_RESET;

   ipa_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] fill_n_ff, fill_n_in;
   logic [CNT_W-1:0] vidx_ff, vidx_in;
   logic             vld_ff, vld_in;
   logic             lowest_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ipa_pkg::ID_W-1:0]    gid_ff, gid_in;
   logic                        granted_ff, granted_in;
   logic                        empty_ff, empty_in;
   logic [ipa_pkg::FC_W-1:0]    count_ff, count_in;
   logic                        ovf_ff, ovf_in;

   logic                        ram_we, ram_re;
   logic [AW-1:0]               ram_wa, ram_ra;
   logic [ipa_pkg::ENTRY_W-1:0] ram_wd, ram_rd;

   ipa_pkg::scan_ctl_type       scan_ctl;
   logic [ipa_pkg::ENTRY_W-1:0] best_val;
   logic [CNT_W-1:0]            best_pos;

   logic             accept;
   logic             cap_write;
   logic [CNT_W-1:0] cap_sat;
   logic [CNT_W-1:0] cnt_m1;
   logic [CNT_W-1:0] vidx_m1;
   logic [CNT_W-1:0] fill_val;

   assign accept    = start && (state_ff == ipa_pkg::ST_IDLE);
   assign cap_write = csr_we && (ipa_pkg::csr_idx_type'(csr_index) == ipa_pkg::CSR_CAPACITY);
   assign cap_sat   = (int'(csr_wdata) > MAX_IDS) ? CNT_W'(MAX_IDS) : CNT_W'(csr_wdata);
   assign cnt_m1    = cnt_ff - CNT_W'(1);
   assign vidx_m1   = vidx_ff - CNT_W'(1);
   assign fill_val  = fill_n_ff - idx_ff - CNT_W'(1);

   ipa_ram #(
      .WIDTH(ipa_pkg::ENTRY_W),
      .DEPTH(MAX_IDS)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_wa),
      .wdata(ram_wd),
      .re   (ram_re),
      .raddr(ram_ra),
      .rdata(ram_rd)
   );

   ipa_min_scan #(
      .POS_W(CNT_W)
   ) u_min_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .val     (ram_rd),
      .pos     (vidx_ff),
      .best_val(best_val),
      .best_pos(best_pos)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ipa_pkg::ST_FILL: begin
            if (idx_ff >= fill_n_ff) begin
               state_in = ipa_pkg::ST_IDLE;
            end
         end
         ipa_pkg::ST_IDLE: begin
            if (accept && ipa_pkg::cmd_type'(req_cmd) == ipa_pkg::CMD_TAKE &&
                cnt_ff != '0) begin
               state_in = lowest_ff ? ipa_pkg::ST_SCAN : ipa_pkg::ST_POP;
            end
         end
         ipa_pkg::ST_POP: begin
            state_in = ipa_pkg::ST_IDLE;
         end
         ipa_pkg::ST_SCAN: begin
            if (idx_ff >= cnt_ff && !vld_ff) begin
               state_in = ipa_pkg::ST_MOVE;
            end
         end
         ipa_pkg::ST_MOVE: begin
            if (idx_ff >= cnt_ff && !vld_ff) begin
               state_in = ipa_pkg::ST_IDLE;
            end
         end
         default: state_in = ipa_pkg::ST_IDLE;
      endcase
      if (cap_write) begin
         state_in = ipa_pkg::ST_FILL;
      end
   end

   always_comb begin
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      fill_n_in    = fill_n_ff;
      vld_in       = 1'b0;
      vidx_in      = vidx_ff;
      ram_we       = 1'b0;
      ram_wa       = idx_ff[AW-1:0];
      ram_wd       = ipa_pkg::ENTRY_W'(fill_val);
      ram_re       = 1'b0;
      ram_ra       = idx_ff[AW-1:0];
      scan_ctl     = '0;
      rsp_valid_in = 1'b0;
      gid_in       = '0;
      granted_in   = 1'b0;
      ovf_in       = 1'b0;
      empty_in     = empty_ff;
      count_in     = count_ff;
      unique case (state_ff)
         ipa_pkg::ST_FILL: begin
            if (idx_ff < fill_n_ff) begin
               ram_we = 1'b1;
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         ipa_pkg::ST_IDLE: begin
            if (accept) begin
               if (ipa_pkg::cmd_type'(req_cmd) == ipa_pkg::CMD_RETURN) begin
                  rsp_valid_in = 1'b1;
                  if (int'(cnt_ff) >= MAX_IDS) begin
                     ovf_in = 1'b1;
                  end else begin
                     ram_we = 1'b1;
                     ram_wa = cnt_ff[AW-1:0];
                     ram_wd = ipa_pkg::ENTRY_W'(req_return_id);
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
                  empty_in = (cnt_in == '0);
                  count_in = ipa_pkg::FC_W'(cnt_in);
               end else if (cnt_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  empty_in     = 1'b1;
                  count_in     = '0;
               end else if (lowest_ff) begin
                  idx_in         = '0;
                  scan_ctl.clear = 1'b1;
               end else begin
                  ram_re = 1'b1;
                  ram_ra = cnt_m1[AW-1:0];
               end
            end
         end
         ipa_pkg::ST_POP: begin
            rsp_valid_in = 1'b1;
            granted_in   = 1'b1;
            gid_in       = ram_rd[ipa_pkg::ID_W-1:0];
            cnt_in       = cnt_m1;
            empty_in     = (cnt_m1 == '0);
            count_in     = ipa_pkg::FC_W'(cnt_m1);
         end
         ipa_pkg::ST_SCAN: begin
            scan_ctl.sample = vld_ff;
            if (idx_ff < cnt_ff) begin
               ram_re  = 1'b1;
               vld_in  = 1'b1;
               vidx_in = idx_ff;
               idx_in  = idx_ff + CNT_W'(1);
            end else if (!vld_ff) begin
               idx_in = best_pos + CNT_W'(1);
            end
         end
         ipa_pkg::ST_MOVE: begin
            if (idx_ff < cnt_ff) begin
               ram_re  = 1'b1;
               vld_in  = 1'b1;
               vidx_in = idx_ff;
               idx_in  = idx_ff + CNT_W'(1);
            end
            if (vld_ff) begin
               ram_we = 1'b1;
               ram_wa = vidx_m1[AW-1:0];
               ram_wd = ram_rd;
            end
            if (idx_ff >= cnt_ff && !vld_ff) begin
               rsp_valid_in = 1'b1;
               granted_in   = 1'b1;
               gid_in       = best_val[ipa_pkg::ID_W-1:0];
               cnt_in       = cnt_m1;
               empty_in     = (cnt_m1 == '0);
               count_in     = ipa_pkg::FC_W'(cnt_m1);
            end
         end
         default: begin
         end
      endcase
      if (cap_write) begin
         fill_n_in = cap_sat;
         cnt_in    = cap_sat;
         idx_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ipa_pkg::ST_FILL;
         cnt_ff       <= CNT_W'(RESET_N);
         fill_n_ff    <= CNT_W'(RESET_N);
         idx_ff       <= '0;
         vld_ff       <= 1'b0;
         lowest_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_n_ff    <= fill_n_in;
         idx_ff       <= idx_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we &&
             ipa_pkg::csr_idx_type'(csr_index) == ipa_pkg::CSR_LOWEST_FIRST) begin
            lowest_ff <= csr_wdata[0];
         end
      end
      vidx_ff    <= vidx_in;
      gid_ff     <= gid_in;
      granted_ff <= granted_in;
      empty_ff   <= empty_in;
      count_ff   <= count_in;
      ovf_ff     <= ovf_in;
   end

   assign busy           = (state_ff != ipa_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = gid_ff;
   assign rsp_granted    = granted_ff;
   assign rsp_pool_empty = empty_ff;
   assign rsp_free_count = count_ff;
   assign rsp_overflow   = ovf_ff;

   a_return_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd) |=> rsp_valid)
      else $error("return beat without response");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= MAX_IDS)
      else $error("free entry count above store size");

   a_move_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ipa_pkg::ST_MOVE && vld_ff) |-> (vidx_ff != '0))
      else $error("compaction write below entry zero");

   a_grant_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_granted && rsp_overflow))
      else $error("response both granted and overflowed");

endmodule

/* bench/id_grant_checker.sv */
module id_grant_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_cmd,
   input  logic [ipa_pkg::ID_W-1:0]      req_return_id,
   input  logic                          rsp_valid,
   input  logic [ipa_pkg::ID_W-1:0]      rsp_granted_id,
   input  logic                          rsp_granted,
   input  logic                          rsp_pool_empty,
   input  logic [ipa_pkg::FC_W-1:0]      rsp_free_count,
   input  logic                          rsp_overflow,
   input  logic                          csr_we,
   input  logic [ipa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ipa_pkg::CAP_W-1:0]     csr_wdata,
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_SIZE = ipa_pkg::MAX_IDS_DEF;

   typedef struct packed {
      logic [ipa_pkg::ID_W-1:0] gid;
      logic                     got;
      logic                     empty;
      logic [ipa_pkg::FC_W-1:0] fc;
      logic                     ovf;
   } grant_type;

   logic [ipa_pkg::ID_W-1:0]  pool_ids [POOL_SIZE];
   int                        pool_len;
   logic [ipa_pkg::CAP_W-1:0] cfg_cap;
   logic                      cfg_low_first;
   grant_type                 grants_due [$];

   function automatic void refill_pool();
      int n;
      n = (cfg_cap > POOL_SIZE) ? POOL_SIZE : int'(cfg_cap);
      for (int i = 0; i < POOL_SIZE; i++) pool_ids[i] = '0;
      for (int i = 0; i < n; i++) pool_ids[i] = ipa_pkg::ID_W'(n - 1 - i);
      pool_len = n;
   endfunction

   function automatic grant_type apply_beat(ipa_pkg::cmd_type c,
                                            logic [ipa_pkg::ID_W-1:0] rid);
      grant_type g;
      int        pos;
      g = '0;
      if (c == ipa_pkg::CMD_TAKE) begin
         if (pool_len > 0) begin
            g.got = 1'b1;
            if (cfg_low_first) begin
               pos = 0;
               for (int i = 1; i < pool_len; i++)
                  if (pool_ids[i] < pool_ids[pos]) pos = i;
               g.gid = pool_ids[pos];
               for (int i = pos; i + 1 < pool_len; i++) pool_ids[i] = pool_ids[i + 1];
            end else begin
               g.gid = pool_ids[pool_len - 1];
            end
            pool_len--;
            pool_ids[pool_len] = '0;
         end
      end else if (pool_len >= POOL_SIZE) begin
         g.ovf = 1'b1;
      end else begin
         pool_ids[pool_len] = rid;
         pool_len++;
      end
      g.empty = (pool_len == 0);
      g.fc    = ipa_pkg::FC_W'(pool_len);
      return g;
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
      cfg_cap    = ipa_pkg::CAP_W'(ipa_pkg::CAP_RESET);
      cfg_low_first = 1'b0;
      refill_pool();
   end

   always @(posedge clock) begin
      grant_type e;
      if (reset) begin
         cfg_cap       = ipa_pkg::CAP_W'(ipa_pkg::CAP_RESET);
         cfg_low_first = 1'b0;
         refill_pool();
         grants_due.delete();
      end else begin
         // response first: a beat in this cycle cannot answer itself
         if (rsp_valid) begin
            if (grants_due.size() == 0) begin
               $error("response beat with nothing pending");
               fail_count++;
            end else begin
               e = grants_due.pop_front();
               if (rsp_granted_id !== e.gid) begin
                  $error("granted_id: expected %0d, actual %0d", e.gid, rsp_granted_id);
                  fail_count++;
               end
               if (rsp_granted !== e.got) begin
                  $error("granted: expected %0d, actual %0d", e.got, rsp_granted);
                  fail_count++;
               end
               if (rsp_pool_empty !== e.empty) begin
                  $error("pool_empty: expected %0d, actual %0d", e.empty, rsp_pool_empty);
                  fail_count++;
               end
               if (rsp_free_count !== e.fc) begin
                  $error("free_count: expected %0d, actual %0d", e.fc, rsp_free_count);
                  fail_count++;
               end
               if (rsp_overflow !== e.ovf) begin
                  $error("overflow: expected %0d, actual %0d", e.ovf, rsp_overflow);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            if (ipa_pkg::csr_idx_type'(csr_index) == ipa_pkg::CSR_CAPACITY) begin
               cfg_cap = csr_wdata;
               refill_pool();
            end else if (ipa_pkg::csr_idx_type'(csr_index) == ipa_pkg::CSR_LOWEST_FIRST) begin
               cfg_low_first = csr_wdata[0];
            end
         end
         if (start && !busy)
            grants_due.push_back(apply_beat(ipa_pkg::cmd_type'(req_cmd), req_return_id));
      end
      pending <= grants_due.size();
   end

endmodule

/* bench/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1800;
   localparam int CYCLE_LIMIT = 1500000;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_cmd;
   logic [ipa_pkg::ID_W-1:0]      req_return_id;
   logic                          rsp_valid;
   logic [ipa_pkg::ID_W-1:0]      rsp_granted_id;
   logic                          rsp_granted;
   logic                          rsp_pool_empty;
   logic [ipa_pkg::FC_W-1:0]      rsp_free_count;
   logic                          rsp_overflow;
   logic                          csr_we;
   logic [ipa_pkg::CSR_IDX_W-1:0] csr_index;
   logic [ipa_pkg::CAP_W-1:0]     csr_wdata;

   int fail_count;
   int pending;
   int cycles;
   int next_gap;
   bit burst;
   int items_sent;

   id_pool_allocator u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_return_id  (req_return_id),
      .rsp_valid      (rsp_valid),
      .rsp_granted_id (rsp_granted_id),
      .rsp_granted    (rsp_granted),
      .rsp_pool_empty (rsp_pool_empty),
      .rsp_free_count (rsp_free_count),
      .rsp_overflow   (rsp_overflow),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   id_grant_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_return_id  (req_return_id),
      .rsp_valid      (rsp_valid),
      .rsp_granted_id (rsp_granted_id),
      .rsp_granted    (rsp_granted),
      .rsp_pool_empty (rsp_pool_empty),
      .rsp_free_count (rsp_free_count),
      .rsp_overflow   (rsp_overflow),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // more: another item follows directly, so start may stay high
   task automatic send_item(input ipa_pkg::cmd_type c, input logic [ipa_pkg::ID_W-1:0] id,
                            input bit more);
      repeat (next_gap) @(posedge clock);
      start         <= 1'b1;
      req_cmd       <= c;
      req_return_id <= id;
      do @(posedge clock); while (busy);
      items_sent++;
      next_gap = burst ? 0 : $urandom_range(0, 5);
      if (!more || next_gap != 0) start <= 1'b0;
   endtask

   task automatic write_reg(input ipa_pkg::csr_idx_type idx,
                            input logic [ipa_pkg::CAP_W-1:0] val);
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      next_gap = $urandom_range(0, 5);
   endtask

   task automatic run_random_phase();
      int n_items;
      int take_pct;
      int pick;
      logic [ipa_pkg::ID_W-1:0] rid;
      n_items  = $urandom_range(40, 120);
      pick     = $urandom_range(0, 2);
      take_pct = (pick == 0) ? 20 : (pick == 1) ? 50 : 80;
      burst    = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n_items; k++) begin
         pick = $urandom_range(0, 9);
         rid  = (pick == 0) ? '0 : (pick == 1) ? '1 : ipa_pkg::ID_W'($urandom_range(0, 63));
         send_item(($urandom_range(1, 100) <= take_pct) ? ipa_pkg::CMD_TAKE :
                   ipa_pkg::CMD_RETURN, rid, k + 1 < n_items);
      end
      burst = 1'b0;
   endtask

   initial begin
      int pick;
      clock         = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      req_cmd       = ipa_pkg::CMD_TAKE;
      req_return_id = '0;
      csr_we        = 1'b0;
      csr_index     = ipa_pkg::CSR_CAPACITY;
      csr_wdata     = '0;
      cycles        = 0;
      items_sent    = 0;
      burst         = 1'b0;
      next_gap      = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // full pool after reset, last-freed policy
      send_item(ipa_pkg::CMD_RETURN, 6'd5, 1'b1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b1);
      send_item(ipa_pkg::CMD_RETURN, 6'd63, 1'b1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b1);
      send_item(ipa_pkg::CMD_RETURN, 6'd0, 1'b1);
      send_item(ipa_pkg::CMD_TAKE, 6'd63, 1'b0);

      write_reg(ipa_pkg::CSR_LOWEST_FIRST, 7'd1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b1);
      send_item(ipa_pkg::CMD_RETURN, 6'd40, 1'b1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b0);

      // empty pool, duplicates
      write_reg(ipa_pkg::CSR_CAPACITY, 7'd0);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b1);
      send_item(ipa_pkg::CMD_RETURN, 6'd63, 1'b1);
      send_item(ipa_pkg::CMD_RETURN, 6'd0, 1'b1);
      send_item(ipa_pkg::CMD_RETURN, 6'd63, 1'b1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b0);

      // capacity beyond the store saturates
      write_reg(ipa_pkg::CSR_CAPACITY, 7'd127);
      send_item(ipa_pkg::CMD_RETURN, 6'd31, 1'b1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b0);

      write_reg(ipa_pkg::CSR_LOWEST_FIRST, 7'd0);
      write_reg(ipa_pkg::CSR_CAPACITY, 7'd1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b1);
      send_item(ipa_pkg::CMD_RETURN, 6'd17, 1'b1);
      send_item(ipa_pkg::CMD_TAKE, 6'd0, 1'b0);

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) >= 3) begin
            pick = $urandom_range(0, 9);
            write_reg(ipa_pkg::CSR_CAPACITY,
                      (pick == 0) ? 7'd0 : (pick == 1) ? 7'd1 : (pick == 2) ? 7'd2 :
                      (pick == 3) ? 7'd64 : (pick == 4) ? 7'd127 :
                      ipa_pkg::CAP_W'($urandom_range(0, 127)));
         end
         write_reg(ipa_pkg::CSR_LOWEST_FIRST, ipa_pkg::CAP_W'($urandom_range(0, 127)));
         run_random_phase();
      end

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* id_pool_allocator.f */
hw/rtl/ipa_pkg.sv
hw/rtl/ipa_ram.sv
hw/rtl/ipa_min_scan.sv
hw/rtl/id_pool_allocator.sv
bench/id_grant_checker.sv
bench/tb.sv
